// ----- sv/bps_pkg.sv -----
package bps_pkg;

	// image geometry and number format
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int FRAC_BITS  = 8;
	localparam int ONE        = 1 << FRAC_BITS;

	// field widths
	localparam int COORD_W  = 16;
	localparam int PIX_W    = 8;
	localparam int CH_W     = 2;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 2;
	localparam int SAMPLE_W = 16;
	localparam int SIZE_W   = 9;

	// derived widths
	localparam int INT_W = COORD_W - FRAC_BITS;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int LIM_W = SIZE_W + FRAC_BITS;
	localparam int WGT_W = FRAC_BITS + 1;
	localparam int H_W   = PIX_W + FRAC_BITS + 1;
	localparam int V_W   = H_W + FRAC_BITS + 1;

	// channel counts
	localparam int RGB_CHANNELS = 3;

	// register reset values
	localparam int RESET_WIDTH  = 256;
	localparam int RESET_HEIGHT = 256;

	// pixel store: four banks split by column and row parity
	localparam int NUM_BANKS  = 4;
	localparam int BANK_SEL_W = $clog2(NUM_BANKS);
	localparam int BANK_DEPTH = RGB_CHANNELS * (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);
	localparam int BANK_AW    = $clog2(BANK_DEPTH);

	// command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	// request modes
	localparam logic [MODE_W-1:0] MODE_WRITE      = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BILINEAR   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_HORIZONTAL = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_CHANNEL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_COORD   = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE   = 2'd2;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_WRITE,
		KIND_SAMPLE
	} kind_t;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [COORD_W-1:0] x_coord;
		logic [COORD_W-1:0] y_coord;
		logic [CH_W-1:0]    channel;
		logic [PIX_W-1:0]   pixel_value;
	} in_req_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample_value;
		logic [STATUS_W-1:0] status;
	} out_rsp_t;

	typedef struct packed {
		logic [SIZE_W-1:0] image_width;
		logic [SIZE_W-1:0] image_height;
		logic              color_mode;
	} cfg_t;

	typedef struct packed {
		kind_t                kind;
		logic [STATUS_W-1:0]  status;
		logic [CH_W-1:0]      channel;
		logic [COL_W-1:0]     col0;
		logic [COL_W-1:0]     col1;
		logic [ROW_W-1:0]     row0;
		logic [ROW_W-1:0]     row1;
		logic [FRAC_BITS-1:0] x_frac;
		logic [FRAC_BITS-1:0] y_frac;
		logic [PIX_W-1:0]     pixel_value;
	} cmd_t;

endpackage

// ----- sv/bps_front.sv -----
module bps_front (
	input  bps_pkg::in_req_t req,
	input  bps_pkg::cfg_t    cfg,
	output bps_pkg::cmd_t    cmd
);

	logic [bps_pkg::SIZE_W-1:0]    w_eff;
	logic [bps_pkg::SIZE_W-1:0]    h_eff;
	logic                          ch_ok;
	logic [bps_pkg::INT_W-1:0]     xi;
	logic [bps_pkg::INT_W-1:0]     yi;
	logic [bps_pkg::FRAC_BITS-1:0] xf;
	logic [bps_pkg::FRAC_BITS-1:0] yf;
	logic [bps_pkg::LIM_W-1:0]     x_lim;
	logic [bps_pkg::LIM_W-1:0]     y_lim;
	logic                          x_over;
	logic                          y_over;
	logic                          xi_over;
	logic                          yi_over;
	logic [bps_pkg::COL_W-1:0]     x0;
	logic [bps_pkg::COL_W-1:0]     x1;
	logic [bps_pkg::ROW_W-1:0]     y0;
	logic [bps_pkg::ROW_W-1:0]     y1;

	// clamp the size registers to 1..max
	always_comb begin
		if (cfg.image_width == '0) begin
			w_eff = bps_pkg::SIZE_W'(1);
		end else if (cfg.image_width > bps_pkg::SIZE_W'(bps_pkg::MAX_WIDTH)) begin
			w_eff = bps_pkg::SIZE_W'(bps_pkg::MAX_WIDTH);
		end else begin
			w_eff = cfg.image_width;
		end
		if (cfg.image_height == '0) begin
			h_eff = bps_pkg::SIZE_W'(1);
		end else if (cfg.image_height > bps_pkg::SIZE_W'(bps_pkg::MAX_HEIGHT)) begin
			h_eff = bps_pkg::SIZE_W'(bps_pkg::MAX_HEIGHT);
		end else begin
			h_eff = cfg.image_height;
		end
	end

	// channel check against the color mode
	assign ch_ok = cfg.color_mode ?
		(req.channel < bps_pkg::CH_W'(bps_pkg::RGB_CHANNELS)) : (req.channel == '0);

	// split coordinates into whole and fraction parts
	assign xi = req.x_coord[bps_pkg::COORD_W-1:bps_pkg::FRAC_BITS];
	assign yi = req.y_coord[bps_pkg::COORD_W-1:bps_pkg::FRAC_BITS];
	assign xf = req.x_coord[bps_pkg::FRAC_BITS-1:0];
	assign yf = req.y_coord[bps_pkg::FRAC_BITS-1:0];

	// fixed-point limits of the last column and row
	assign x_lim = {(w_eff - bps_pkg::SIZE_W'(1)), {bps_pkg::FRAC_BITS{1'b0}}};
	assign y_lim = {(h_eff - bps_pkg::SIZE_W'(1)), {bps_pkg::FRAC_BITS{1'b0}}};
	assign x_over = bps_pkg::LIM_W'(req.x_coord) > x_lim;
	assign y_over = bps_pkg::LIM_W'(req.y_coord) > y_lim;
	assign xi_over = bps_pkg::SIZE_W'(xi) >= w_eff;
	assign yi_over = bps_pkg::SIZE_W'(yi) >= h_eff;

	// neighbor columns and rows; an exact coordinate reuses the same pixel
	assign x0 = xi[bps_pkg::COL_W-1:0];
	assign y0 = yi[bps_pkg::ROW_W-1:0];
	assign x1 = x0 + bps_pkg::COL_W'(xf != '0);
	assign y1 = y0 + bps_pkg::ROW_W'(yf != '0);

	// classify the request
	always_comb begin
		cmd.kind        = bps_pkg::KIND_NONE;
		cmd.status      = bps_pkg::ST_OK;
		cmd.channel     = req.channel;
		cmd.col0        = x0;
		cmd.col1        = x0;
		cmd.row0        = y0;
		cmd.row1        = y0;
		cmd.x_frac      = xf;
		cmd.y_frac      = yf;
		cmd.pixel_value = req.pixel_value;
		case (req.mode)
			bps_pkg::MODE_WRITE: begin
				if (!ch_ok) begin
					cmd.status = bps_pkg::ST_BAD_CHANNEL;
				end else if (xi_over || yi_over) begin
					cmd.status = bps_pkg::ST_BAD_COORD;
				end else begin
					cmd.kind = bps_pkg::KIND_WRITE;
				end
			end
			bps_pkg::MODE_BILINEAR: begin
				cmd.col1 = x1;
				cmd.row1 = y1;
				if (!ch_ok) begin
					cmd.status = bps_pkg::ST_BAD_CHANNEL;
				end else if (x_over || y_over) begin
					cmd.status = bps_pkg::ST_BAD_COORD;
				end else begin
					cmd.kind = bps_pkg::KIND_SAMPLE;
				end
			end
			bps_pkg::MODE_HORIZONTAL: begin
				cmd.col1   = x1;
				cmd.y_frac = '0;
				if (!ch_ok) begin
					cmd.status = bps_pkg::ST_BAD_CHANNEL;
				end else if (x_over || yi_over) begin
					cmd.status = bps_pkg::ST_BAD_COORD;
				end else begin
					cmd.kind = bps_pkg::KIND_SAMPLE;
				end
			end
			default: begin
				cmd.kind = bps_pkg::KIND_NONE;
			end
		endcase
	end

endmodule

// ----- sv/bps_queue.sv -----
module bps_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bps_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output bps_pkg::cmd_t pop_data,
	output logic          empty
);

	logic [bps_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [bps_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [bps_pkg::QCNT_W-1:0] count_q;
	bps_pkg::cmd_t              entry_q [bps_pkg::QUEUE_DEPTH];

	assign full     = count_q == bps_pkg::QCNT_W'(bps_pkg::QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign pop_data = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + bps_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + bps_pkg::QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + bps_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - bps_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- sv/bps_back.sv -----
module bps_back (
	input  logic              clk,
	input  logic              arst_n,
	input  bps_pkg::cmd_t     cmd,
	input  logic              cmd_valid,
	output logic              cmd_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output bps_pkg::out_rsp_t out_rsp
);

	logic                                               advance;
	logic [bps_pkg::BANK_SEL_W-1:0]                     wr_bank;
	logic [bps_pkg::NUM_BANKS-1:0][bps_pkg::PIX_W-1:0]  rd_s1;

	// stage 1: bank read data and selection
	logic                          valid_s1;
	bps_pkg::kind_t                kind_s1;
	logic [bps_pkg::STATUS_W-1:0]  status_s1;
	logic                          x0p_s1;
	logic                          x1p_s1;
	logic                          y0p_s1;
	logic                          y1p_s1;
	logic [bps_pkg::FRAC_BITS-1:0] xf_s1;
	logic [bps_pkg::FRAC_BITS-1:0] yf_s1;

	// stage 2: row blends
	logic                          valid_s2;
	logic                          zero_s2;
	logic [bps_pkg::STATUS_W-1:0]  status_s2;
	logic [bps_pkg::H_W-1:0]       h0_s2;
	logic [bps_pkg::H_W-1:0]       h1_s2;
	logic [bps_pkg::FRAC_BITS-1:0] yf_s2;

	// output register
	logic              out_valid_q;
	bps_pkg::out_rsp_t out_rsp_q;

	logic [bps_pkg::PIX_W-1:0]           p00;
	logic [bps_pkg::PIX_W-1:0]           p10;
	logic [bps_pkg::PIX_W-1:0]           p01;
	logic [bps_pkg::PIX_W-1:0]           p11;
	logic [bps_pkg::WGT_W-1:0]           wx0;
	logic [bps_pkg::WGT_W-1:0]           wy0;
	logic [bps_pkg::H_W-1:0]             h0;
	logic [bps_pkg::H_W-1:0]             h1;
	logic [bps_pkg::V_W-1:0]             v;
	logic [bps_pkg::V_W-bps_pkg::FRAC_BITS-1:0] v_scaled;
	logic [bps_pkg::SAMPLE_W-1:0]        sample;

	// whole pipeline moves when the output register can take a result
	assign advance   = !out_valid_q || out_ready;
	assign cmd_pop   = advance && cmd_valid;
	assign wr_bank   = {cmd.row0[0], cmd.col0[0]};
	assign out_valid = out_valid_q;
	assign out_rsp   = out_rsp_q;

	// parity banks: each holds the pixels of one column and row parity
	for (genvar g = 0; g < bps_pkg::NUM_BANKS; g++) begin : g_bank
		localparam logic [bps_pkg::BANK_SEL_W-1:0] BSEL = bps_pkg::BANK_SEL_W'(g);

		logic [bps_pkg::COL_W-1:0]   col;
		logic [bps_pkg::ROW_W-1:0]   row;
		logic [bps_pkg::BANK_AW-1:0] addr;
		logic [bps_pkg::PIX_W-1:0]   mem [bps_pkg::BANK_DEPTH];

		// pick the neighbor column and row of this bank's parity
		assign col  = (cmd.col0[0] == BSEL[0]) ? cmd.col0 : cmd.col1;
		assign row  = (cmd.row0[0] == BSEL[1]) ? cmd.row0 : cmd.row1;
		assign addr = {cmd.channel, row[bps_pkg::ROW_W-1:1], col[bps_pkg::COL_W-1:1]};

		always_ff @(posedge clk) begin
			if (cmd_pop) begin
				if (cmd.kind == bps_pkg::KIND_WRITE && wr_bank == BSEL) begin
					mem[addr] <= cmd.pixel_value;
				end
				rd_s1[g] <= mem[addr];
			end
		end
	end

	// route bank data back to the four neighbors
	assign p00 = rd_s1[{y0p_s1, x0p_s1}];
	assign p10 = rd_s1[{y0p_s1, x1p_s1}];
	assign p01 = rd_s1[{y1p_s1, x0p_s1}];
	assign p11 = rd_s1[{y1p_s1, x1p_s1}];

	// horizontal blend of both rows
	assign wx0 = bps_pkg::WGT_W'(bps_pkg::ONE) - bps_pkg::WGT_W'(xf_s1);
	assign h0  = bps_pkg::H_W'(p00) * bps_pkg::H_W'(wx0)
	           + bps_pkg::H_W'(p10) * bps_pkg::H_W'(xf_s1);
	assign h1  = bps_pkg::H_W'(p01) * bps_pkg::H_W'(wx0)
	           + bps_pkg::H_W'(p11) * bps_pkg::H_W'(xf_s1);

	// vertical blend, truncate and saturate
	assign wy0      = bps_pkg::WGT_W'(bps_pkg::ONE) - bps_pkg::WGT_W'(yf_s2);
	assign v        = bps_pkg::V_W'(h0_s2) * bps_pkg::V_W'(wy0)
	                + bps_pkg::V_W'(h1_s2) * bps_pkg::V_W'(yf_s2);
	assign v_scaled = v[bps_pkg::V_W-1:bps_pkg::FRAC_BITS];
	always_comb begin
		if (|v_scaled[bps_pkg::V_W-bps_pkg::FRAC_BITS-1:bps_pkg::SAMPLE_W]) begin
			sample = '1;
		end else begin
			sample = v_scaled[bps_pkg::SAMPLE_W-1:0];
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= cmd_pop;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (advance) begin
			kind_s1   <= cmd.kind;
			status_s1 <= cmd.status;
			x0p_s1    <= cmd.col0[0];
			x1p_s1    <= cmd.col1[0];
			y0p_s1    <= cmd.row0[0];
			y1p_s1    <= cmd.row1[0];
			xf_s1     <= cmd.x_frac;
			yf_s1     <= cmd.y_frac;

			zero_s2   <= kind_s1 != bps_pkg::KIND_SAMPLE;
			status_s2 <= status_s1;
			h0_s2     <= h0;
			h1_s2     <= h1;
			yf_s2     <= yf_s1;

			out_rsp_q.sample_value <= zero_s2 ? '0 : sample;
			out_rsp_q.status       <= status_s2;
		end
	end

endmodule

// ----- sv/bilinear_pixel_sampler.sv -----
// Bilinear pixel sampler with an on-chip image store of 8-bit pixels.
// Input channel (in_valid/in_ready/in_req): each request writes one pixel or
// asks for a bilinear or a horizontal linear sample at an unsigned Q8.8
// coordinate. Output channel (out_valid/out_ready/out_rsp): exactly one
// response per request, in request order, with a Q8.8 sample (zero for
// writes and errors) and a status code.
// Configuration: cfg_we/cfg_index/cfg_data write image width, image height
// and color mode; write them only while no request is in flight.
// Throughput: one request per cycle while out_ready is high. The four
// neighbors come from four memories banked by column and row parity, so
// each bank sees one access. A request passes through the queue, the bank
// read, the row blend and the vertical blend into the output register.
// When the receiver stalls, the back pipeline holds and the 4-entry command
// queue keeps taking requests until full, then in_ready drops.
// Reset clears the queue and the pipeline valids and sets the image to 256 x
// 256, one channel; pixel contents are undefined until written.
module bilinear_pixel_sampler (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  bps_pkg::in_req_t                  in_req,
	output logic                              out_valid,
	input  logic                              out_ready,
	output bps_pkg::out_rsp_t                 out_rsp,
	input  logic                              cfg_we,
	input  logic [bps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bps_pkg::SIZE_W-1:0]        cfg_data
);

	logic [bps_pkg::SIZE_W-1:0] image_width_q;
	logic [bps_pkg::SIZE_W-1:0] image_height_q;
	logic                       color_mode_q;
	bps_pkg::cfg_t              cfg;
	bps_pkg::cmd_t              front_cmd;
	bps_pkg::cmd_t              head_cmd;
	logic                       q_full;
	logic                       q_empty;
	logic                       q_pop;
	logic                       q_push;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= bps_pkg::SIZE_W'(bps_pkg::RESET_WIDTH);
			image_height_q <= bps_pkg::SIZE_W'(bps_pkg::RESET_HEIGHT);
			color_mode_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				bps_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				bps_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				bps_pkg::REG_COLOR_MODE:   color_mode_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.image_width  = image_width_q;
	assign cfg.image_height = image_height_q;
	assign cfg.color_mode   = color_mode_q;

	// request intake
	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	bps_front u_front (
		.req (in_req),
		.cfg (cfg),
		.cmd (front_cmd)
	);

	bps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (front_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (head_cmd),
		.empty     (q_empty)
	);

	bps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (head_cmd),
		.cmd_valid (!q_empty),
		.cmd_pop   (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_rsp   (out_rsp)
	);

endmodule
